@@ rtl/hss_pkg.sv @@
// Package for the half-step stepper sequencer: field widths, action and
// register codes, and the half-step coil pattern table.
// No dependencies.
package hss_pkg;

    localparam int ACTION_W   = 2;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 24;
    localparam int COIL_W     = 4;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // The half-step pattern has eight entries.
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_W     = $clog2(PHASE_COUNT);

    localparam logic [TIME_W-1:0] STEP_PERIOD_RST = 32'd10000;
    localparam logic [POS_W-1:0]  MOTOR_STEPS_RST = 16'd4096;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK        = 2'd0,
        ACT_ROTATE_CNT  = 2'd1,
        ACT_ROTATE_CONT = 2'd2,
        ACT_STOP        = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_PERIOD = 1'd0,
        REG_MOTOR_STEPS = 1'd1
    } t_reg_index;

    function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pattern;
        case (phase)
            3'd0:    pattern = 4'b1000;
            3'd1:    pattern = 4'b1100;
            3'd2:    pattern = 4'b0100;
            3'd3:    pattern = 4'b0110;
            3'd4:    pattern = 4'b0010;
            3'd5:    pattern = 4'b0011;
            3'd6:    pattern = 4'b0001;
            3'd7:    pattern = 4'b1001;
            default: pattern = 4'b0000;
        endcase
        return pattern;
    endfunction

endpackage

@@ rtl/hss_if.sv @@
// Channel interfaces of the half-step stepper sequencer: command input,
// result output and configuration write. Depends on hss_pkg.
interface hss_in_if;
    logic                             valid;
    logic                             ready;
    logic [hss_pkg::ACTION_W-1:0]     action;
    logic [hss_pkg::TIME_W-1:0]       now_us;
    logic                             direction;
    logic [hss_pkg::COUNT_W-1:0]      step_count;

    modport source(output valid, action, now_us, direction, step_count, input ready);
    modport sink(input valid, action, now_us, direction, step_count, output ready);
endinterface

interface hss_out_if;
    logic                             valid;
    logic                             ready;
    logic [hss_pkg::COIL_W-1:0]       coil_pattern;
    logic                             stepped;
    logic                             finished;
    logic [hss_pkg::POS_W-1:0]        position;
    logic                             running;

    modport source(output valid, coil_pattern, stepped, finished, position, running,
                   input ready);
    modport sink(input valid, coil_pattern, stepped, finished, position, running,
                 output ready);
endinterface

interface hss_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hss_pkg::CFG_IDX_W-1:0]    index;
    logic [hss_pkg::CFG_DATA_W-1:0]   data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/half_step_stepper_sequencer.sv @@
// Top level of the half-step stepper sequencer: input register, state
// update and result register. Depends on hss_pkg and the interfaces in hss_if.
//
// Usage:
// Each word on i_in carries an action (tick, rotate by a step count, rotate
// continuously, stop) with a microsecond time stamp. Every word gives exactly
// one result word on o_out: coil drive bits, the stepped and finished flags,
// the position and the running flag, all as they stand after that word.
// A tick takes a half step once one step period has passed since the last
// step start; the start time then advances by exactly one period.
// i_cfg writes the step period (index 0) and the steps per revolution
// (index 1). It is always ready and is meant to be used while idle.
// A word waits in the input register; the state update and the result are
// then registered into the result register. One word is accepted every
// cycle while the receiver takes results; the combinational state update sets that rate.
// When the receiver stalls, the result register holds and the input
// register fills; i_in drops ready only once both are full.
// Reset stops the motor, turns all coils off, clears position and phase,
// and loads a 10000 us period and 4096 steps per revolution.
module half_step_stepper_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hss_in_if.sink             i_in,
    hss_out_if.source          o_out,
    hss_cfg_if.sink            i_cfg
);

    localparam int PW = hss_pkg::PHASE_W;
    localparam int SW = hss_pkg::POS_W;
    localparam int TW = hss_pkg::TIME_W;
    localparam int CW = hss_pkg::COUNT_W;

    // Configuration registers.
    logic [TW-1:0] r_period;
    logic [SW-1:0] r_motor_steps;

    // Input register.
    logic                 r_in_valid;
    hss_pkg::t_action     r_action;
    logic [TW-1:0]        r_now;
    logic                 r_dir;
    logic [CW-1:0]        r_count;

    // Motor state.
    logic          r_halted,    n_halted;
    logic          r_backward,  n_backward;
    logic [CW-1:0] r_steps_left, n_steps_left;
    logic [TW-1:0] r_last_time, n_last_time;
    logic [PW-1:0] r_phase,     n_phase;
    logic [SW-1:0] r_pos,       n_pos;
    logic [hss_pkg::COIL_W-1:0] r_coil, n_coil;
    logic          n_stepped, n_finished;

    // Result register.
    logic                       r_out_valid;
    logic [hss_pkg::COIL_W-1:0] r_out_coil;
    logic                       r_out_stepped;
    logic                       r_out_finished;
    logic [SW-1:0]              r_out_pos;
    logic                       r_out_running;

    logic          out_free;
    logic          advance;
    logic [TW-1:0] elapsed;
    logic [SW:0]   pos_inc;
    logic [CW-1:0] steps_dec;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign i_cfg.ready = 1'b1;

    assign elapsed   = r_now - r_last_time;
    assign pos_inc   = {1'b0, r_pos} + {{SW{1'b0}}, 1'b1};
    assign steps_dec = r_steps_left - {{(CW-1){1'b0}}, 1'b1};

    always_comb begin
        n_halted     = r_halted;
        n_backward   = r_backward;
        n_steps_left = r_steps_left;
        n_last_time  = r_last_time;
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_coil       = r_coil;
        n_stepped    = 1'b0;
        n_finished   = 1'b0;
        case (r_action)
            hss_pkg::ACT_TICK: begin
                if (!r_halted && (elapsed >= r_period)) begin
                    n_last_time = r_last_time + r_period;
                    if (!r_backward) begin
                        n_phase = r_phase + {{(PW-1){1'b0}}, 1'b1};
                        // Positions past the limit (after a lower limit) wrap to zero.
                        n_pos = (pos_inc > {1'b0, r_motor_steps}) ? '0 : pos_inc[SW-1:0];
                    end else begin
                        n_phase = r_phase - {{(PW-1){1'b0}}, 1'b1};
                        n_pos   = (r_pos == '0) ? r_motor_steps
                                                : r_pos - {{(SW-1){1'b0}}, 1'b1};
                    end
                    n_coil    = hss_pkg::coil_lookup(n_phase);
                    n_stepped = 1'b1;
                    // A zero goal means run without end.
                    if (r_steps_left != '0) begin
                        n_steps_left = steps_dec;
                        if (steps_dec == '0) begin
                            n_halted   = 1'b1;
                            n_finished = 1'b1;
                        end
                    end
                end
            end
            hss_pkg::ACT_ROTATE_CNT: begin
                n_halted     = 1'b0;
                n_backward   = r_dir;
                n_steps_left = r_count;
                n_last_time  = r_now;
            end
            hss_pkg::ACT_ROTATE_CONT: begin
                n_halted     = 1'b0;
                n_backward   = r_dir;
                n_steps_left = '0;
                n_last_time  = r_now;
            end
            hss_pkg::ACT_STOP: begin
                n_halted = 1'b1;
            end
            default: begin
                n_halted = r_halted;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= hss_pkg::STEP_PERIOD_RST;
            r_motor_steps <= hss_pkg::MOTOR_STEPS_RST;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_halted      <= 1'b1;
            r_backward    <= 1'b0;
            r_steps_left  <= '0;
            r_last_time   <= '0;
            r_phase       <= '0;
            r_pos         <= '0;
            r_coil        <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (hss_pkg::t_reg_index'(i_cfg.index))
                    hss_pkg::REG_STEP_PERIOD: r_period      <= i_cfg.data;
                    hss_pkg::REG_MOTOR_STEPS: r_motor_steps <= i_cfg.data[SW-1:0];
                    default:                  r_period      <= r_period;
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_halted     <= n_halted;
                r_backward   <= n_backward;
                r_steps_left <= n_steps_left;
                r_last_time  <= n_last_time;
                r_phase      <= n_phase;
                r_pos        <= n_pos;
                r_coil       <= n_coil;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_action <= hss_pkg::t_action'(i_in.action);
            r_now    <= i_in.now_us;
            r_dir    <= i_in.direction;
            r_count  <= i_in.step_count;
        end
        if (advance) begin
            r_out_coil     <= n_coil;
            r_out_stepped  <= n_stepped;
            r_out_finished <= n_finished;
            r_out_pos      <= n_pos;
            r_out_running  <= !n_halted;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.coil_pattern = r_out_coil;
    assign o_out.stepped      = r_out_stepped;
    assign o_out.finished     = r_out_finished;
    assign o_out.position     = r_out_pos;
    assign o_out.running      = r_out_running;

endmodule

@@ rtl/hss_checker.sv @@
// Port-level checker for the half-step stepper sequencer and the bind that
// attaches it to the top level. Depends on hss_pkg.
module hss_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [hss_pkg::COIL_W-1:0] i_coil_pattern,
    input logic                       i_stepped,
    input logic                       i_finished,
    input logic                       i_running
);

    // No result may appear in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word shown right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // Reaching the goal always comes with the final step and stops the motor.
    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_finished |-> i_stepped && !i_running)
        else $error("finished without a step or with the motor running");

    // A motor that stepped keeps running unless that step ended the goal.
    a_step_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stepped |-> i_running || i_finished)
        else $error("step reported while stopped");

    // After any step some coil is energized.
    a_coil_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stepped |-> i_coil_pattern != '0)
        else $error("step taken with all coils off");

endmodule

bind half_step_stepper_sequencer hss_checker u_hss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_coil_pattern (o_out.coil_pattern),
    .i_stepped      (o_out.stepped),
    .i_finished     (o_out.finished),
    .i_running      (o_out.running)
);
